/* hw/rtl/hmng_pkg.sv */
// Shared constants for the heightmap normal generator.
`timescale 1ns / 1ps

package hmng_pkg;

  // default grid limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_LENGTH_DEF = 1024;

  // configuration register indexes
  localparam logic [2:0] CFG_MAP_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_MAP_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_GAIN_X      = 3'd2;
  localparam logic [2:0] CFG_GAIN_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_GAIN_Z      = 3'd4;

  // register reset values
  localparam logic [10:0] MAP_WIDTH_RST   = 11'd256;
  localparam logic [10:0] MAP_LENGTH_RST  = 11'd256;
  localparam logic [15:0] GAIN_X_RST      = 16'd0;
  localparam logic [15:0] GAIN_HEIGHT_RST = 16'd256;
  localparam logic [15:0] GAIN_Z_RST      = 16'd0;

endpackage

/* hw/rtl/hmng_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module hmng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hw/rtl/heightmap_normal_generator.sv */
// Heightmap normal generator: central-difference vertex normals, Q1.15 output.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in      | in  | in_valid/in_stall  | in_height (Q8.8)
//  out     | out | out_valid/out_stall| out_normal_x/y/z (Q1.15), out_column,
//          |     |                    | out_row, out_map_done
//  cfg     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
//  Steps: a beat passes accept, row-store read and write-back, then for each
//  normal it produces (0 to 3) come the gain products, the squares, the
//  bit-pair square root and the restoring divider, which is shared by the
//  three components.
//  Reset: synchronous, active low; row stores hold no reset value, counters
//  and recent samples clear. One beat is worked on at a time; the output
//  register lets the next beat enter while the last normal waits out a stall.

module heightmap_normal_generator
  import hmng_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_height,
  // output beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [9:0]         out_column,
  output logic [9:0]         out_row,
  output logic               out_map_done,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_LENGTH);
  localparam int CWX = (XW + 1 > 11) ? XW + 1 : 11;
  localparam int CWY = (YW + 1 > 11) ? YW + 1 : 11;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD2  = 3'd1;
  localparam logic [2:0] S_WB   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // vertex kinds produced by one beat
  localparam logic [1:0] V_ABOVE = 2'd0;  // vertex of the previous row
  localparam logic [1:0] V_LEFT  = 2'd1;  // last row, one column back
  localparam logic [1:0] V_LAST  = 2'd2;  // final vertex of the grid

  // neighbor terms in accumulation order
  localparam logic [1:0] K_B = 2'd0;  // row above
  localparam logic [1:0] K_C = 2'd1;  // column right
  localparam logic [1:0] K_D = 2'd2;  // row below
  localparam logic [1:0] K_E = 2'd3;  // column left

  // ---------------- configuration ----------------
  logic [10:0] cfg_map_width_r, cfg_map_length_r;
  logic [15:0] cfg_gain_x_r, cfg_gain_height_r, cfg_gain_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_map_width_r   <= MAP_WIDTH_RST;
      cfg_map_length_r  <= MAP_LENGTH_RST;
      cfg_gain_x_r      <= GAIN_X_RST;
      cfg_gain_height_r <= GAIN_HEIGHT_RST;
      cfg_gain_z_r      <= GAIN_Z_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:   cfg_map_width_r   <= cfg_wdata[10:0];
        CFG_MAP_LENGTH:  cfg_map_length_r  <= cfg_wdata[10:0];
        CFG_GAIN_X:      cfg_gain_x_r      <= cfg_wdata;
        CFG_GAIN_HEIGHT: cfg_gain_height_r <= cfg_wdata;
        CFG_GAIN_Z:      cfg_gain_z_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective last column / last row (sizes clamped to [2, MAX])
  logic [CWX-1:0] wext;
  logic [CWY-1:0] lext;
  logic [XW-1:0]  wlast;
  logic [YW-1:0]  llast;

  always_comb begin
    wext = CWX'(cfg_map_width_r);
    lext = CWY'(cfg_map_length_r);
    if (wext < CWX'(2))              wlast = XW'(1);
    else if (wext > CWX'(MAX_WIDTH)) wlast = XW'(MAX_WIDTH - 1);
    else                             wlast = XW'(wext - CWX'(1));
    if (lext < CWY'(2))               llast = YW'(1);
    else if (lext > CWY'(MAX_LENGTH)) llast = YW'(MAX_LENGTH - 1);
    else                              llast = YW'(lext - CWY'(1));
  end

  // ---------------- position and item registers ----------------
  logic [2:0]  state_r, state_nxt;
  logic [XW-1:0] col_cnt_r, x_cur, x_r;
  logic [YW-1:0] row_cnt_r, r_cur, r_r;
  logic [15:0] rec0_r, rec1_r;      // previous row at column before, previous beat
  logic [15:0] h_r, a_r, b_r, c_r, p2_r, e0_r, last_r;
  logic [2:0]  vmask_r;
  logic [1:0]  vi_r;
  logic        accept;

  assign x_cur  = (col_cnt_r < wlast) ? col_cnt_r : wlast;
  assign r_cur  = (row_cnt_r < llast) ? row_cnt_r : llast;
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  // ---------------- row stores ----------------
  logic [15:0] prev_rd_a, prev_rd_b, older_rd_a;
  logic        prev_re;
  logic [XW-1:0] prev_ra, prev_rb;
  logic        wb_we;

  assign prev_re = accept || (state_r == S_RD2);
  assign prev_ra = (state_r == S_IDLE) ? x_cur : XW'(x_r - XW'(2));
  assign prev_rb = XW'(x_cur + XW'(1));
  assign wb_we   = (state_r == S_WB);

  hmng_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_prev_row (
    .clk     (clk),
    .we      (wb_we),
    .waddr   (x_r),
    .wdata   (h_r),
    .re      (prev_re),
    .raddr_a (prev_ra),
    .raddr_b (prev_rb),
    .rdata_a (prev_rd_a),
    .rdata_b (prev_rd_b)
  );

  hmng_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_older_row (
    .clk     (clk),
    .we      (wb_we),
    .waddr   (x_r),
    .wdata   (a_r),
    .re      (accept),
    .raddr_a (x_cur),
    .raddr_b (x_cur),
    .rdata_a (older_rd_a),
    .rdata_b ()
  );

  // vertices a beat produces, in emission order
  logic [2:0] wb_mask, rest_mask, sel_mask;
  logic [1:0] sel_vi;

  always_comb begin
    wb_mask[V_ABOVE] = (r_r != '0);
    wb_mask[V_LEFT]  = (r_r == llast) && (x_r != '0);
    wb_mask[V_LAST]  = (r_r == llast) && (x_r == wlast);
    rest_mask = vmask_r & ~(3'b001 << vi_r);
    sel_mask  = (state_r == S_WB) ? wb_mask : rest_mask;
    if (sel_mask[V_ABOVE])     sel_vi = V_ABOVE;
    else if (sel_mask[V_LEFT]) sel_vi = V_LEFT;
    else                       sel_vi = V_LAST;
  end

  // ---------------- vertex operand selection ----------------
  logic [15:0] ha, hb, hc, hd, he;
  logic        pb, pc, pd, pe, vdone;
  logic [9:0]  vcol, vrow;

  always_comb begin
    unique case (vi_r)
      V_ABOVE: begin
        ha = a_r; hb = b_r; hc = c_r; hd = h_r; he = e0_r;
        pb = (int'(r_r) >= 2); pc = (x_r < wlast); pd = 1'b1; pe = (x_r != '0);
        vcol = 10'(x_r); vrow = 10'(r_r - YW'(1)); vdone = 1'b0;
      end
      V_LEFT: begin
        ha = last_r; hb = e0_r; hc = h_r; hd = h_r; he = p2_r;
        pb = 1'b1; pc = 1'b1; pd = 1'b0; pe = (int'(x_r) >= 2);
        vcol = 10'(x_r - XW'(1)); vrow = 10'(r_r); vdone = 1'b0;
      end
      default: begin
        ha = h_r; hb = a_r; hc = h_r; hd = h_r; he = last_r;
        pb = 1'b1; pc = 1'b0; pd = 1'b0; pe = (x_r != '0);
        vcol = 10'(x_r); vrow = 10'(r_r); vdone = 1'b1;
      end
    endcase
  end

  // ---------------- gain products: one neighbor per cycle ----------------
  logic [2:0]         mcnt_r;
  logic [1:0]         pk_r;
  logic [1:0]         kk;
  logic [15:0]        hn;
  logic               pn;
  logic signed [16:0] diff, offv, off_r;
  logic signed [32:0] prod, prod_r;
  logic signed [33:0] dterm;
  logic signed [34:0] accx_r, accz_r;

  always_comb begin
    kk = mcnt_r[1:0];
    unique case (kk)
      K_B: begin hn = hb; pn = pb; offv = -$signed({cfg_gain_z_r[15], cfg_gain_z_r}); end
      K_C: begin hn = hc; pn = pc; offv =  $signed({cfg_gain_x_r[15], cfg_gain_x_r}); end
      K_D: begin hn = hd; pn = pd; offv =  $signed({cfg_gain_z_r[15], cfg_gain_z_r}); end
      default: begin
        hn = he; pn = pe; offv = -$signed({cfg_gain_x_r[15], cfg_gain_x_r});
      end
    endcase
    diff  = $signed({hn[15], hn}) - $signed({ha[15], ha});
    prod  = $signed(cfg_gain_height_r) * diff;
    dterm = $signed({prod_r[32], prod_r}) + $signed({{9{off_r[16]}}, off_r, 8'b0});
  end

  // ---------------- magnitudes, squares ----------------
  logic [1:0]  scnt_r;
  logic [34:0] ax, az, atop;
  logic [1:0]  sh;
  logic [30:0] axs_r, ays_r, azs_r;
  logic [1:0]  s_r;
  logic        sx_r, sz_r;
  logic [30:0] mop;
  logic [61:0] msq_r;
  logic [63:0] sum_r, ay2;

  always_comb begin
    ax   = accx_r[34] ? 35'(-accx_r) : 35'(accx_r);
    az   = accz_r[34] ? 35'(-accz_r) : 35'(accz_r);
    atop = ax | az;
    if (atop[34:33] != '0)   sh = 2'd3;
    else if (atop[32])       sh = 2'd2;
    else if (atop[31])       sh = 2'd1;
    else                     sh = 2'd0;
    mop = (scnt_r == 2'd1) ? axs_r : azs_r;
    ay2 = 64'(1) << (6'd34 - 6'({s_r, 1'b0}));
  end

  // ---------------- square root, two radicand bits per cycle ----------------
  logic [4:0]  rcnt_r;
  logic [63:0] radic_r;
  logic [33:0] rrem_r, rrem_t, rtrial;
  logic [31:0] root_r;

  assign rrem_t = {rrem_r[31:0], radic_r[63:62]};
  assign rtrial = {root_r, 2'b01};

  // ---------------- restoring divider, one quotient bit per cycle ----------------
  logic [1:0]  dcomp_r;
  logic [4:0]  dstep_r;
  logic [30:0] dmag;
  logic        dneg;
  logic [46:0] dnum;
  logic [31:0] drem_r;
  logic [15:0] dlow_r, q_r, qsat, qres;
  logic [32:0] dtr;
  logic [15:0] nx_r, ny_r, nz_r;

  always_comb begin
    unique case (dcomp_r)
      2'd0:    begin dmag = axs_r; dneg = sx_r; end
      2'd1:    begin dmag = ays_r; dneg = 1'b0; end
      default: begin dmag = azs_r; dneg = sz_r; end
    endcase
    dnum = {dmag, 16'b0} - 47'({dmag, 15'b0}) + 47'(root_r >> 1);
    dtr  = {drem_r, dlow_r[15]};
    qsat = q_r[15] ? 16'h7FFF : q_r;
    qres = dneg ? 16'(-qsat) : qsat;
  end

  // ---------------- output register ----------------
  logic        out_valid_r, out_free;
  logic [15:0] out_nx_r, out_ny_r, out_nz_r;
  logic [9:0]  out_col_r, out_row_r;
  logic        out_done_r;

  assign out_free = !out_valid_r || !out_stall;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RD2;
      S_RD2:  state_nxt = S_WB;
      S_WB:   state_nxt = (wb_mask != '0) ? S_MUL : S_IDLE;
      S_MUL:  if (mcnt_r == 3'd4) state_nxt = S_SQ;
      S_SQ:   if (scnt_r == 2'd3) state_nxt = S_ROOT;
      S_ROOT: if (rcnt_r == 5'd31) state_nxt = S_DIV;
      S_DIV:  if (dstep_r == 5'd17 && dcomp_r == 2'd2) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = (rest_mask != '0) ? S_MUL : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      rec0_r      <= '0;
      rec1_r      <= '0;
      vmask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new normal loads in S_OUT; otherwise a taken beat empties the register
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (accept) begin
          h_r    <= in_height;
          x_r    <= x_cur;
          r_r    <= r_cur;
          e0_r   <= rec0_r;
          last_r <= rec1_r;
          if (x_cur == wlast) begin
            col_cnt_r <= '0;
            row_cnt_r <= (r_cur == llast) ? '0 : YW'(r_cur + YW'(1));
          end else begin
            col_cnt_r <= XW'(x_cur + XW'(1));
            row_cnt_r <= r_cur;
          end
        end
        S_RD2: begin
          a_r <= prev_rd_a;
          c_r <= prev_rd_b;
          b_r <= older_rd_a;
        end
        S_WB: begin
          p2_r    <= prev_rd_a;
          rec0_r  <= a_r;
          rec1_r  <= h_r;
          vmask_r <= wb_mask;
          vi_r    <= sel_vi;
          mcnt_r  <= '0;
          accx_r  <= '0;
          accz_r  <= '0;
        end
        S_MUL: begin
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r != 3'd4) begin
            prod_r <= pn ? prod : '0;
            off_r  <= pn ? offv : '0;
            pk_r   <= kk;
          end
          if (mcnt_r != 3'd0) begin
            unique case (pk_r)
              K_B: accz_r <= accz_r + 35'(dterm);
              K_C: accx_r <= accx_r - 35'(dterm);
              K_D: accz_r <= accz_r - 35'(dterm);
              default: accx_r <= accx_r + 35'(dterm);
            endcase
          end
          scnt_r <= '0;
        end
        S_SQ: begin
          scnt_r <= scnt_r + 2'd1;
          unique case (scnt_r)
            2'd0: begin
              axs_r <= 31'(ax >> sh);
              azs_r <= 31'(az >> sh);
              ays_r <= 31'(35'd131072 >> sh);
              s_r   <= sh;
              sx_r  <= accx_r[34];
              sz_r  <= accz_r[34];
            end
            2'd1: msq_r <= mop * mop;
            2'd2: begin
              sum_r <= ay2 + 64'(msq_r);
              msq_r <= mop * mop;
            end
            default: sum_r <= sum_r + 64'(msq_r);
          endcase
          rcnt_r  <= '0;
          rrem_r  <= '0;
          root_r  <= '0;
        end
        S_ROOT: begin
          if (rcnt_r == 5'd0 && root_r == '0 && rrem_r == '0) begin
            // first pair comes straight from the freshly summed radicand
          end
          rcnt_r <= rcnt_r + 5'd1;
          if (rrem_t >= rtrial) begin
            rrem_r <= rrem_t - rtrial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rrem_r <= rrem_t;
            root_r <= {root_r[30:0], 1'b0};
          end
          radic_r <= {radic_r[61:0], 2'b00};
          dcomp_r <= '0;
          dstep_r <= '0;
        end
        S_DIV: begin
          if (dstep_r == 5'd0) begin
            drem_r  <= 32'(dnum[46:16]);
            dlow_r  <= dnum[15:0];
            q_r     <= '0;
            dstep_r <= 5'd1;
          end else if (dstep_r != 5'd17) begin
            if (dtr >= {1'b0, root_r}) begin
              drem_r <= 32'(dtr - {1'b0, root_r});
              q_r    <= {q_r[14:0], 1'b1};
            end else begin
              drem_r <= 32'(dtr);
              q_r    <= {q_r[14:0], 1'b0};
            end
            dlow_r  <= {dlow_r[14:0], 1'b0};
            dstep_r <= dstep_r + 5'd1;
          end else begin
            unique case (dcomp_r)
              2'd0:    nx_r <= qres;
              2'd1:    ny_r <= qres;
              default: nz_r <= qres;
            endcase
            dcomp_r <= dcomp_r + 2'd1;
            dstep_r <= '0;
          end
        end
        S_OUT: if (out_free) begin
          out_valid_r <= 1'b1;
          out_nx_r    <= nx_r;
          out_ny_r    <= ny_r;
          out_nz_r    <= nz_r;
          out_col_r   <= vcol;
          out_row_r   <= vrow;
          out_done_r  <= vdone;
          vmask_r     <= rest_mask;
          vi_r        <= sel_vi;
          mcnt_r      <= '0;
          accx_r      <= '0;
          accz_r      <= '0;
        end
        default: ;
      endcase

      // radicand loads as the sum of squares completes
      if (state_r == S_SQ && scnt_r == 2'd3) radic_r <= sum_r + 64'(msq_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_nx_r;
  assign out_normal_y = out_ny_r;
  assign out_normal_z = out_nz_r;
  assign out_column   = out_col_r;
  assign out_row      = out_row_r;
  assign out_map_done = out_done_r;

  // ---------------- assertions ----------------
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_RD2)
    else $error("accepted beat did not start the row-store read");

  a_vertex_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_OUT) |-> vmask_r[vi_r])
    else $error("working on a vertex that is not pending");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> root_r != '0)
    else $error("zero divisor in normalization");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt != S_OUT) |-> out_free)
    else $error("normal loaded over an untaken output beat");

endmodule

/* test/heightmap_normal_checker.sv */
// Checker for the heightmap normal generator: predicts normals and compares output beats.
`timescale 1ns / 1ps

module heightmap_normal_checker
  import hmng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_height,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_normal_x,
  input  logic [15:0] out_normal_y,
  input  logic [15:0] out_normal_z,
  input  logic [9:0]  out_column,
  input  logic [9:0]  out_row,
  input  logic        out_map_done,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          normals_owed
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        done;
  } normal_t;

  normal_t     owed_normals[$];
  logic [15:0] row_above[MAX_WIDTH_DEF];
  logic [15:0] row_two_above[MAX_WIDTH_DEF];
  logic [15:0] diag_height, last_height;
  int          col_pos, row_pos;
  logic [10:0] width_reg, length_reg;
  logic [15:0] gain_x, gain_h, gain_z;

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // neighbour height difference in Q16.16, zero when clamped
  function automatic longint height_delta(bit present, logic [15:0] hn, logic [15:0] hv,
                                          longint step);
    if (!present) return 0;
    return sx16(gain_h) * (sx16(hn) - sx16(hv)) + step * 256;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] to_q15(bit neg, longint unsigned mag, longint unsigned m);
    longint unsigned q = (mag * 32768 + m / 2) / m;
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic void push_normal(logic [15:0] hv,
                                      bit pb, logic [15:0] hb, bit pc, logic [15:0] hc,
                                      bit pd, logic [15:0] hd, bit pe, logic [15:0] he,
                                      int col, int row, bit done);
    longint          db, dc, dd, de, vx, vz;
    longint unsigned ax, ay, az, m;
    normal_t         n;
    db = height_delta(pb, hb, hv, -sx16(gain_z));
    dc = height_delta(pc, hc, hv, sx16(gain_x));
    dd = height_delta(pd, hd, hv, sx16(gain_z));
    de = height_delta(pe, he, hv, -sx16(gain_x));
    vx = de - dc;
    vz = db - dd;
    ax = vx < 0 ? -vx : vx;
    ay = 131072;
    az = vz < 0 ? -vz : vz;
    // pre-shift so the squares fit in 64 bits
    while (ax >= 64'd1 << 31 || az >= 64'd1 << 31) begin
      ax >>= 1;
      ay >>= 1;
      az >>= 1;
    end
    m = int_sqrt(ax * ax + ay * ay + az * az);
    n.nx   = to_q15(vx < 0, ax, m);
    n.ny   = to_q15(0, ay, m);
    n.nz   = to_q15(vz < 0, az, m);
    n.col  = 10'(col);
    n.row  = 10'(row);
    n.done = done;
    owed_normals.push_back(n);
  endfunction

  function automatic void take_height(logic [15:0] h);
    int          w, l, x, r;
    logic [15:0] a, b, e0, lst;
    w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : int'(width_reg));
    l = length_reg < 2 ? 2 : (length_reg > MAX_LENGTH_DEF ? MAX_LENGTH_DEF : int'(length_reg));
    x = col_pos < w - 1 ? col_pos : w - 1;
    r = row_pos < l - 1 ? row_pos : l - 1;
    a = row_above[x];
    b = row_two_above[x];
    e0 = diag_height;
    lst = last_height;
    if (r >= 1)
      push_normal(a, r >= 2, b, x + 1 < w, x + 1 < w ? row_above[x + 1] : 16'd0,
                  1, h, x >= 1, e0, x, r - 1, 0);
    if (r == l - 1 && x >= 1)
      push_normal(lst, 1, e0, 1, h, 0, 16'd0, x >= 2, x >= 2 ? row_above[x - 2] : 16'd0,
                  x - 1, r, 0);
    if (r == l - 1 && x == w - 1)
      push_normal(h, 1, a, 0, 16'd0, 0, 16'd0, x >= 1, lst, x, r, 1);
    row_two_above[x] = a;
    row_above[x] = h;
    diag_height = a;
    last_height = h;
    if (x == w - 1) begin
      col_pos = 0;
      row_pos = (r == l - 1) ? 0 : r + 1;
    end else begin
      col_pos = x + 1;
      row_pos = r;
    end
  endfunction

  initial begin
    mismatches = 0;
    normals_owed = 0;
    foreach (row_above[i]) begin
      row_above[i] = '0;
      row_two_above[i] = '0;
    end
  end

  always @(posedge clk) begin
    normal_t got, want;
    if (!rst_n) begin
      width_reg <= MAP_WIDTH_RST;
      length_reg <= MAP_LENGTH_RST;
      gain_x <= GAIN_X_RST;
      gain_h <= GAIN_HEIGHT_RST;
      gain_z <= GAIN_Z_RST;
      diag_height = '0;
      last_height = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAP_WIDTH:   width_reg <= cfg_wdata[10:0];
          CFG_MAP_LENGTH:  length_reg <= cfg_wdata[10:0];
          CFG_GAIN_X:      gain_x <= cfg_wdata;
          CFG_GAIN_HEIGHT: gain_h <= cfg_wdata;
          CFG_GAIN_Z:      gain_z <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_height(in_height);
      if (out_valid && !out_stall) begin
        got = '{out_normal_x, out_normal_y, out_normal_z, out_column, out_row, out_map_done};
        if (owed_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected normal beat %p", $realtime, got);
        end else begin
          want = owed_normals.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: normal mismatch\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
    end
    normals_owed = owed_normals.size();
  end

endmodule

/* test/heightmap_normal_generator_tb.sv */
// Testbench top for the heightmap normal generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module heightmap_normal_generator_tb;
  import hmng_pkg::*;

  // wait a beat may need before its normals are out (up to three normals)
  localparam int DRAIN_CYCLES = 400;
  localparam int IDLE_LIMIT   = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic [9:0]         out_column, out_row;
  logic               out_map_done;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  int mismatches, normals_owed;
  int heights_sent = 0;
  bit calm = 0;        // no idling on either side (final stretch)
  bit squeeze = 0;     // asks the receiver for one long hold-off
  bit gappy = 1;       // sender inserts bursts of gaps in this grid
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  heightmap_normal_generator dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_height,
    .out_valid, .out_stall, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_column, .out_row, .out_map_done,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  heightmap_normal_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_height,
    .out_valid, .out_stall, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_column, .out_row, .out_map_done,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .mismatches, .normals_owed
  );

  // watchdog: stretches with no beat and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: runs of open cycles, bursts of stall, one long hold-off on request
  initial begin
    bit squeezed;
    squeezed = 0;
    @(posedge rst_n);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // wait for every owed normal, then for a beat that may still be in flight
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (normals_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(logic [10:0] w, logic [10:0] l, logic [15:0] gx, logic [15:0] gh,
                       logic [15:0] gz);
    drain();
    write_reg(CFG_MAP_WIDTH, {5'd0, w});
    write_reg(CFG_MAP_LENGTH, {5'd0, l});
    write_reg(CFG_GAIN_X, gx);
    write_reg(CFG_GAIN_HEIGHT, gh);
    write_reg(CFG_GAIN_Z, gz);
  endtask

  // one beat; valid stays high into the next beat unless a gap follows
  task automatic send_height(logic [15:0] h);
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_height = h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    heights_sent++;
    if (heights_sent == 100) squeeze = 1;
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'd0;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_grids(int cells, int grids);
    repeat (grids) begin
      gappy = $urandom_range(0, 2) != 0;
      repeat (cells) send_height(rand_height());
    end
  endtask

  initial begin
    logic [15:0] corner_heights[9] = '{16'h8000, 16'h7FFF, 16'h0000,
                                       16'h7FFF, 16'h8000, 16'hFFFF,
                                       16'h0001, 16'h8000, 16'h7FFF};
    int w, l;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 3x3 grid with full-scale heights and gains: exercises the pre-shift
    setup(11'd3, 11'd3, 16'h7FFF, 16'h8000, 16'h8000);
    foreach (corner_heights[i]) send_height(corner_heights[i]);
    // sizes below the minimum act as 2x2
    setup(11'd0, 11'd1, 16'd0, 16'd256, 16'd0);
    send_height(16'h0000);
    send_height(16'h7FFF);
    send_height(16'h8000);
    send_height(16'h0100);
    // 4x3 with opposite extremes
    setup(11'd4, 11'd3, 16'h8000, 16'h7FFF, 16'h7FFF);
    repeat (12) send_height(rand_height());

    // random small grids
    while (heights_sent < 280) begin
      w = $urandom_range(2, 8);
      l = $urandom_range(2, 6);
      setup(11'(w), 11'(l), rand_gain(), rand_gain(), rand_gain());
      send_grids(w * l, $urandom_range(1, 2));
    end

    // final stretch with no idling
    calm = 1;
    while (heights_sent < 415) begin
      w = $urandom_range(2, 6);
      l = $urandom_range(2, 5);
      setup(11'(w), 11'(l), rand_gain(), rand_gain(), rand_gain());
      send_grids(w * l, 1);
    end

    drain();
    if (mismatches == 0 && normals_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* heightmap_normal_generator.f */
hw/rtl/hmng_pkg.sv
hw/rtl/hmng_ram.sv
hw/rtl/heightmap_normal_generator.sv
test/heightmap_normal_checker.sv
test/heightmap_normal_generator_tb.sv
